// ----- hdl/utf8_stream_decoder_assert.svh -----
// Assertion macros shared by the UTF-8 stream decoder modules.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the using module.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define UTF8SD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define UTF8SD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/utf8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: field widths, code point limits,
// byte classes and the queue entry type. No dependencies.
package utf8sd_pkg;

    localparam int BYTE_W          = 8;
    localparam int CP_W            = 21;
    localparam int PAY_W           = 7;
    localparam int OUT_TDATA_W     = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

    // Class of one input byte as seen by the front end.
    typedef enum logic [2:0] {
        K_ASCII,
        K_LEAD2,
        K_LEAD3,
        K_LEAD4,
        K_CONT,
        K_SKIP
    } t_kind;

    // One classified word waiting in the queue.
    typedef struct packed {
        t_kind             kind;
        logic [PAY_W-1:0]  payload;
        logic              chunk_end;
    } t_entry;

endpackage

// ----- hdl/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder: front end, word queue and back end.
// Depends on utf8sd_pkg, utf8sd_front, utf8sd_queue and utf8sd_back.
//
//  Channel   Dir  Data bits (low to high)          tlast       tuser
//  s_axis    in   tdata[7:0] text_byte             chunk_end   -
//  m_axis    out  tdata[20:0] code_point, 3 zeros  -           -
//
//  One byte is accepted per cycle while the queue has room; one word per cycle leaves it
//  while the output register is free or being drained. A byte enters the queue when accepted;
//  when popped, a code point it completes goes into the output register and sets m_axis_tvalid.
//  The back end stalls only while a held result is not taken; the queue absorbs up to
//  QUEUE_DEPTH bytes before s_axis_tready drops.
//  Synchronous active-low reset clears the queue, the open sequence and the output valid.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = utf8sd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [utf8sd_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] text_byte
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [utf8sd_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [20:0] code_point, [23:21] zero
);
    import utf8sd_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_q_valid;
    logic   w_pop;
    t_entry w_in_entry;
    t_entry w_head;

    utf8sd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_entry       (w_in_entry)
    );

    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_entry (w_head)
    );

    utf8sd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_entry       (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- hdl/utf8sd_front.sv -----
// Front end of the UTF-8 stream decoder: accepts input words and classifies each byte.
// Depends on utf8sd_pkg.
module utf8sd_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [utf8sd_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    input  logic                          i_q_full,
    output logic                          o_push,
    output utf8sd_pkg::t_entry            o_entry
);
    import utf8sd_pkg::*;

    // Accept whenever the queue has room.
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    // Classify the byte and keep only its payload bits.
    always_comb begin
        o_entry.chunk_end = s_axis_tlast;
        o_entry.kind      = K_SKIP;
        o_entry.payload   = '0;
        priority if (s_axis_tdata[7] == 1'b0) begin
            o_entry.kind    = K_ASCII;
            o_entry.payload = s_axis_tdata[6:0];
        end else if (s_axis_tdata[7:6] == 2'b10) begin
            o_entry.kind    = K_CONT;
            o_entry.payload = {1'b0, s_axis_tdata[5:0]};
        end else if (s_axis_tdata[7:5] == 3'b110) begin
            o_entry.kind    = K_LEAD2;
            o_entry.payload = {2'b0, s_axis_tdata[4:0]};
        end else if (s_axis_tdata[7:4] == 4'b1110) begin
            o_entry.kind    = K_LEAD3;
            o_entry.payload = {3'b0, s_axis_tdata[3:0]};
        end else if (s_axis_tdata[7:3] == 5'b11110) begin
            o_entry.kind    = K_LEAD4;
            o_entry.payload = {4'b0, s_axis_tdata[2:0]};
        end else begin
            o_entry.kind    = K_SKIP;
            o_entry.payload = '0;
        end
    end

endmodule

// ----- hdl/utf8sd_queue.sv -----
// Short queue of classified words between the front and back ends.
// Depends on utf8sd_pkg and utf8_stream_decoder_assert.svh.
module utf8sd_queue #(
    parameter int DEPTH = utf8sd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  utf8sd_pkg::t_entry i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output utf8sd_pkg::t_entry o_entry
);
    import utf8sd_pkg::*;
    `include "utf8_stream_decoder_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Storage for the queued words.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `UTF8SD_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `UTF8SD_ASSERT(a_count_up, w_wr && !w_rd |=> r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

// ----- hdl/utf8sd_back.sv -----
// Back end of the UTF-8 stream decoder: assembles code points and holds the output register.
// Depends on utf8sd_pkg and utf8_stream_decoder_assert.svh.
module utf8sd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  utf8sd_pkg::t_entry                 i_entry,
    output logic                               o_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [utf8sd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import utf8sd_pkg::*;
    `include "utf8_stream_decoder_assert.svh"

    logic [1:0]      r_pend;
    logic [CP_W-1:0] r_part;
    logic            r_out_valid;
    logic [CP_W-1:0] r_out_cp;

    logic [1:0]      n_pend;
    logic [CP_W-1:0] n_part;
    logic            w_have;
    logic [CP_W-1:0] w_cp;
    logic [CP_W-1:0] w_shift;
    logic            w_emit;

    // A word leaves the queue whenever the output register is free or being drained.
    assign o_pop   = i_q_valid && (!r_out_valid || m_axis_tready);
    assign w_shift = {r_part[CP_W-7:0], i_entry.payload[5:0]};

    // Sequence state update for the word at the head of the queue.
    always_comb begin
        n_pend = '0;
        n_part = '0;
        w_have = 1'b0;
        w_cp   = '0;
        if (r_pend != 2'd0 && i_entry.kind == K_CONT) begin
            n_pend = r_pend - 2'd1;
            if (r_pend == 2'd1) begin
                w_have = 1'b1;
                w_cp   = w_shift;
            end else begin
                n_part = w_shift;
            end
        end else begin
            // Any open sequence is abandoned and the byte starts fresh.
            unique case (i_entry.kind)
                K_ASCII: begin
                    w_have = 1'b1;
                    w_cp   = CP_W'(i_entry.payload);
                end
                K_LEAD2: begin
                    n_pend = 2'd1;
                    n_part = CP_W'(i_entry.payload);
                end
                K_LEAD3: begin
                    n_pend = 2'd2;
                    n_part = CP_W'(i_entry.payload);
                end
                K_LEAD4: begin
                    n_pend = 2'd3;
                    n_part = CP_W'(i_entry.payload);
                end
                K_CONT, K_SKIP: begin
                    n_pend = '0;
                end
                default: begin
                    n_pend = '0;
                end
            endcase
        end
        // The end of a chunk closes whatever is still open.
        if (i_entry.chunk_end) begin
            n_pend = '0;
            n_part = '0;
        end
    end

    // Only scalar values leave the block: no surrogates, nothing above the last plane.
    assign w_emit = w_have && (w_cp <= CP_MAX) && !((w_cp >= SURR_LO) && (w_cp <= SURR_HI));

    // Sequence state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_part      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pend <= n_pend;
                r_part <= n_part;
            end
            if (o_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out_cp <= w_cp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - CP_W)'(0), r_out_cp};

    `UTF8SD_ASSERT(a_chunk_closes, o_pop && i_entry.chunk_end |=> r_pend == 2'd0, "sequence still open after chunk end")
    `UTF8SD_ASSERT(a_part_narrow, r_pend != 2'd0 |-> r_part[CP_W-1:15] == '0, "partial value too wide for open sequence")

endmodule

// ----- sim/tb_utf8_stream_decoder.sv -----
// Self-checking testbench for utf8_stream_decoder: drives text bytes with chunk marks,
// predicts each decoded code point and compares it with every word taken from m_axis.
// Depends on utf8sd_pkg and the RTL of utf8_stream_decoder.
module tb_utf8_stream_decoder;

    import utf8sd_pkg::*;

    localparam int IDLE_PCT    = 12;
    localparam int BYTE_TARGET = 1950;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 20;
    localparam int QUIET_FROM  = 800;
    localparam int QUIET_TO    = 1400;

    // One text byte with its chunk mark.
    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              chunk_end;
    } t_text_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;   // [7:0] text_byte
    logic                   s_axis_tlast = 1'b0; // chunk_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [20:0] code_point, [23:21] zero

    t_text_word        text_feed_q[$];
    logic [CP_W-1:0]   code_point_q[$];
    logic [CP_W-1:0]   seq_acc = '0;
    logic [1:0]        seq_left = '0;
    int                err_cnt = 0;
    int                stall_cnt = 0;
    int                cycle_cnt = 0;
    logic              quiet;

    utf8_stream_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a period of four units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // A stretch in the middle of the run where neither side idles.
    assign quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

    // Sorts a byte the way a decoder sees it at the start of a sequence.
    function automatic t_kind byte_kind(input logic [BYTE_W-1:0] b);
        if (!b[7])
            return K_ASCII;
        else if (b[7:6] == 2'b10)
            return K_CONT;
        else if (b[7:5] == 3'b110)
            return K_LEAD2;
        else if (b[7:4] == 4'b1110)
            return K_LEAD3;
        else if (b[7:3] == 5'b11110)
            return K_LEAD4;
        return K_SKIP;
    endfunction

    // Advances the decoder state by one byte and tells whether a code point comes out.
    function automatic logic decode_byte(input logic [BYTE_W-1:0] b, input logic chunk_end,
                                         output logic [CP_W-1:0] cp);
        logic hit;
        t_kind kind;
        hit = 1'b0;
        cp = '0;
        kind = byte_kind(b);
        if (seq_left != 2'd0 && kind == K_CONT) begin
            seq_acc = {seq_acc[CP_W-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
                cp = seq_acc;
                hit = 1'b1;
                seq_acc = '0;
            end
        end else begin
            // Any open sequence is abandoned and the byte starts afresh.
            seq_left = 2'd0;
            seq_acc = '0;
            case (kind)
                K_ASCII: begin
                    cp = {{(CP_W-BYTE_W){1'b0}}, b};
                    hit = 1'b1;
                end
                K_LEAD2: begin
                    seq_acc = {{(CP_W-5){1'b0}}, b[4:0]};
                    seq_left = 2'd1;
                end
                K_LEAD3: begin
                    seq_acc = {{(CP_W-4){1'b0}}, b[3:0]};
                    seq_left = 2'd2;
                end
                K_LEAD4: begin
                    seq_acc = {{(CP_W-3){1'b0}}, b[2:0]};
                    seq_left = 2'd3;
                end
                default: begin
                end
            endcase
        end
        if (chunk_end) begin
            seq_left = 2'd0;
            seq_acc = '0;
        end
        if (hit && (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)))
            hit = 1'b0;
        return hit;
    endfunction

    // Driver: presents queued bytes on s_axis and predicts each accepted word.
    always @(posedge i_clk) begin : drive_proc
        logic [CP_W-1:0] cp;
        t_text_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (decode_byte(s_axis_tdata, s_axis_tlast, cp))
                    code_point_q.push_back(cp);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (text_feed_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    w = text_feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= w.text;
                    s_axis_tlast <= w.chunk_end;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls m_axis at random and checks every word taken against the oldest prediction.
    always @(posedge i_clk) begin : check_proc
        logic [CP_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            if (m_axis_tvalid && m_axis_tready) begin
                if (code_point_q.size() == 0) begin
                    $display("%0t: unexpected code point, expected none, actual %h",
                             $time, m_axis_tdata[CP_W-1:0]);
                    err_cnt <= err_cnt + 1;
                end else begin
                    want = code_point_q.pop_front();
                    if (m_axis_tdata[CP_W-1:0] !== want) begin
                        $display("%0t: code point mismatch, expected %h, actual %h",
                                 $time, want, m_axis_tdata[CP_W-1:0]);
                        err_cnt <= err_cnt + 1;
                    end
                end
            end
        end
    end

    // Counts cycles and cycles in which neither side moves a word.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
    end

    // Watchdog: ends the run when nothing has moved for too long.
    initial begin
        while (stall_cnt < STALL_LIMIT)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic chunk_end);
        text_feed_q.push_back('{text: b, chunk_end: chunk_end});
    endtask

    // Queues one sequence of n bytes with random payload; keep < n truncates it.
    task automatic add_sequence(input int n, input int keep);
        logic [BYTE_W-1:0] b;
        int k;
        case (n)
            1: b = {1'b0, 7'($urandom)};
            2: b = {3'b110, 5'($urandom)};
            3: b = {4'b1110, 4'($urandom)};
            default: b = {5'b11110, 3'($urandom)};
        endcase
        // Steer some three-byte sequences to lead byte ED, in and around the surrogate range.
        if (n == 3 && $urandom_range(9) == 0)
            b = 8'hED;
        add_byte(b, keep == 1 && $urandom_range(99) < 8);
        for (k = 1; k < keep; k++)
            add_byte({2'b10, 6'($urandom)},
                     (k == keep - 1) ? ($urandom_range(99) < 8) : ($urandom_range(99) < 3));
    endtask

    // Stimulus and end of run.
    initial begin
        int n;
        int r;
        // Directed part: extremes and each special case.
        add_byte(8'h00, 1'b0);                                   // smallest ASCII
        add_byte(8'h7F, 1'b1);                                   // largest ASCII at chunk end
        add_byte(8'hC2, 1'b0); add_byte(8'hA9, 1'b0);            // two-byte character
        add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
        add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0);            // largest scalar value
        add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0);            // above the top of the range
        add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0); // surrogate
        add_byte(8'hC0, 1'b0); add_byte(8'h80, 1'b0);            // overlong zero
        add_byte(8'h80, 1'b0); add_byte(8'hBF, 1'b0);            // stray continuations
        add_byte(8'hF8, 1'b0); add_byte(8'hFF, 1'b0);            // invalid leads
        add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b0);            // interrupted by ASCII
        add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);            // unfinished at chunk end
        add_byte(8'hAC, 1'b0);                                   // now a stray byte
        add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0);            // all payload bits set
        add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b1);            // sequence ending at chunk end
        // Random part: mostly well-formed sequences, some broken ones and some noise.
        while (text_feed_q.size() < BYTE_TARGET) begin
            r = $urandom_range(99);
            if (r < 12) begin
                add_byte(8'($urandom), $urandom_range(99) < 10);
            end else if (r < 22) begin
                n = $urandom_range(2, 4);
                add_sequence(n, $urandom_range(1, n - 1));
            end else begin
                n = $urandom_range(1, 4);
                add_sequence(n, n);
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the stimulus run out, then the expected words drain, then a short tail.
        while (text_feed_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (code_point_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
